// ===== rtl/isf_pkg.sv =====
`timescale 1ns / 1ps
package isf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WID_W      = 11;
	localparam int HGT_W      = 13;
	localparam int CFG_W      = 13;
	localparam int CQ_DEPTH   = 4;
	localparam int CQ_AW      = $clog2(CQ_DEPTH);
	localparam int OQ_DEPTH   = 16;
	localparam int OQ_AW      = $clog2(OQ_DEPTH);
	localparam int OQ_CW      = $clog2(OQ_DEPTH + 1);

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [1:0] MODE_SOBEL  = 2'd0;
	localparam logic [1:0] MODE_LAPL   = 2'd1;
	localparam logic [1:0] MODE_WALLIS = 2'd2;

	// largest sobel square sum whose rounded-up root still fits 255
	localparam logic [20:0] SOBEL_LIMIT = 21'd65025;

	typedef struct packed {
		logic [7:0] gray_pixel;
		logic       drain;
	} item_t;

	typedef struct packed {
		logic [7:0] out_pixel;
		logic       frame_last;
	} result_t;

	typedef struct packed {
		logic [WID_W-1:0] w;
		logic [HGT_W-1:0] h;
		logic             restart;
	} geom_t;

	typedef struct packed {
		logic             drain;
		logic             emit;
		logic             border;
		logic             last;
		logic [7:0]       pix;
		logic [COL_W-1:0] col;
		logic             sel;
	} cmd_t;

	typedef struct packed {
		logic [15:0] x;
		logic [7:0]  root;
		logic [9:0]  rem;
	} sq_st_t;

	// one digit of the restoring square root
	function automatic sq_st_t sqrt_step(sq_st_t s);
		sq_st_t     n;
		logic [11:0] tmp;
		logic [11:0] trial;
		tmp   = {s.rem, s.x[15:14]};
		trial = {2'b00, s.root, 2'b01};
		n.x   = {s.x[13:0], 2'b00};
		if (tmp >= trial) begin
			n.rem  = 10'(tmp - trial);
			n.root = {s.root[6:0], 1'b1};
		end else begin
			n.rem  = tmp[9:0];
			n.root = {s.root[6:0], 1'b0};
		end
		return n;
	endfunction

endpackage

// ===== rtl/inverted_edge_stencil_3x3_top.sv =====
`timescale 1ns / 1ps
// an accepted transfer passes the command queue, the bank read (s1), stages s2 to s9 and the result queue
// throughput: one item per cycle, set by the single-port line banks and the credit count
// against the 16-entry result queue; issue stalls while every credit is in use
// reset: arst_n clears counters, queues and window at once; registers go to
// sobel, 640 x 480; line banks stay unknown until written
module inverted_edge_stencil_3x3_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  isf_pkg::item_t         sample,
	output logic                   empty,
	input  logic                   pop,
	output isf_pkg::result_t       result,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [isf_pkg::CFG_W-1:0] cfg_data
);
	import isf_pkg::*;

	// configuration registers
	logic [1:0]       mode_q;
	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;

	geom_t geom;
	logic  cq_push;
	logic  cq_full;
	logic  cq_pop;
	logic  cq_empty;
	cmd_t  cmd_in;
	cmd_t  cmd_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SOBEL;
			width_q  <= WID_W'(640);
			height_q <= HGT_W'(480);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data[WID_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HGT_W-1:0];
				default:    ;
			endcase
		end
	end

	// geometry is clamped into the supported range on use
	always_comb begin
		if (width_q < WID_W'(3)) begin
			geom.w = WID_W'(3);
		end else if (width_q > WID_W'(MAX_WIDTH)) begin
			geom.w = WID_W'(MAX_WIDTH);
		end else begin
			geom.w = width_q;
		end
		if (height_q < HGT_W'(3)) begin
			geom.h = HGT_W'(3);
		end else if (height_q > HGT_W'(MAX_HEIGHT)) begin
			geom.h = HGT_W'(MAX_HEIGHT);
		end else begin
			geom.h = height_q;
		end
		// a geometry write restarts the stream
		geom.restart = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));
	end

	assign full = cq_full;

	// front end: position tracking and classification of each transfer
	isf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.push    (push),
		.sample  (sample),
		.cq_full (cq_full),
		.cq_push (cq_push),
		.cmd     (cmd_in)
	);

	// short command queue decoupling the two halves
	isf_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.wdata  (cmd_in),
		.full   (cq_full),
		.pop    (cq_pop),
		.empty  (cq_empty),
		.rdata  (cmd_out)
	);

	// back end: line banks, window, filter pipeline, result queue
	isf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.cq_empty (cq_empty),
		.cmd      (cmd_out),
		.cq_pop   (cq_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);
endmodule

// ===== rtl/isf_cmdq.sv =====
`timescale 1ns / 1ps
module isf_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  isf_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output isf_pkg::cmd_t rdata
);
	import isf_pkg::*;

	cmd_t             mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_q;
	logic [CQ_AW-1:0] rd_q;
	logic [CQ_AW:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== rtl/isf_front.sv =====
`timescale 1ns / 1ps
module isf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  isf_pkg::geom_t geom,
	input  logic           push,
	input  isf_pkg::item_t sample,
	input  logic           cq_full,
	output logic           cq_push,
	output isf_pkg::cmd_t  cmd
);
	import isf_pkg::*;

	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic [WID_W-1:0] pend_q;
	logic             tog_q;

	logic [COL_W-1:0] w_m1;
	logic [ROW_W-1:0] h_m1;
	logic             accept;
	logic             pin_zero;
	logic             emit_px;
	logic             emit_dr;
	logic             emit;
	logic             out_last_col;
	logic             out_last_row;

	assign w_m1         = COL_W'(geom.w - 1'b1);
	assign h_m1         = ROW_W'(geom.h - 1'b1);
	assign accept       = push && !cq_full;
	assign pin_zero     = (in_col_q == '0) && (in_row_q == '0);
	assign emit_px      = (pend_q == WID_W'(geom.w + 1'b1));
	assign emit_dr      = pin_zero && (pend_q != '0);
	assign emit         = sample.drain ? emit_dr : emit_px;
	assign out_last_col = (out_col_q == w_m1);
	assign out_last_row = (out_row_q == h_m1);

	// a drain that finds nothing to flush leaves no trace
	assign cq_push = accept && (!sample.drain || emit_dr);

	always_comb begin
		cmd.drain  = sample.drain;
		cmd.emit   = emit;
		cmd.border = (out_row_q == '0) || out_last_row || (out_col_q == '0) || out_last_col;
		cmd.last   = out_last_row && out_last_col;
		cmd.pix    = sample.gray_pixel;
		cmd.col    = sample.drain ? out_col_q : in_col_q;
		// pixel: write bank, drain: bank holding the wanted row
		cmd.sel    = sample.drain ? (out_last_row ? !tog_q : tog_q) : tog_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
			tog_q     <= 1'b0;
		end else if (geom.restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
		end else if (accept) begin
			if (!sample.drain) begin
				if (in_col_q == w_m1) begin
					in_col_q <= '0;
					tog_q    <= !tog_q;
					in_row_q <= (in_row_q == h_m1) ? '0 : in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (!emit_px) begin
					pend_q <= pend_q + 1'b1;
				end
			end else if (emit_dr) begin
				pend_q <= pend_q - 1'b1;
			end
			if (emit) begin
				if (out_last_col) begin
					out_col_q <= '0;
					out_row_q <= out_last_row ? '0 : out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end
endmodule

// ===== rtl/isf_back.sv =====
`timescale 1ns / 1ps
module isf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       mode,
	input  logic             cq_empty,
	input  isf_pkg::cmd_t    cmd,
	output logic             cq_pop,
	output logic             empty,
	input  logic             pop,
	output isf_pkg::result_t result
);
	import isf_pkg::*;

	typedef struct packed {
		logic       pass;
		logic [7:0] val;
		logic       last;
	} pt_t;

	logic [7:0] bank0_q [MAX_WIDTH];
	logic [7:0] bank1_q [MAX_WIDTH];
	logic [7:0] rd0_q;
	logic [7:0] rd1_q;
	logic [7:0] win_q [3][3];

	logic [OQ_CW-1:0] used_q;
	logic             issue;

	logic       v_s1;
	cmd_t       cmd_s1;
	logic       v_s2;
	pt_t        pt_s2;
	logic       v_s3;
	pt_t        pt_s3;
	logic [9:0] alap_s3;
	logic [9:0] dxa_s3;
	logic [9:0] dya_s3;
	logic       v_s4;
	pt_t        pt_s4;
	logic [9:0] alap_s4;
	logic [19:0] dxx_s4;
	logic [19:0] dyy_s4;
	logic       v_s5;
	pt_t        pt_s5;
	logic [9:0] alap_s5;
	logic       over_s5;
	sq_st_t     st_s5;
	logic       v_s6;
	pt_t        pt_s6;
	logic [9:0] alap_s6;
	logic       over_s6;
	sq_st_t     st_s6;
	logic       v_s7;
	pt_t        pt_s7;
	logic [9:0] alap_s7;
	logic       over_s7;
	sq_st_t     st_s7;
	logic       v_s8;
	pt_t        pt_s8;
	logic [9:0] alap_s8;
	logic       over_s8;
	sq_st_t     st_s8;
	logic       v_s9;
	pt_t        pt_s9;
	logic [9:0] alap_s9;
	logic       over_s9;
	sq_st_t     st_s9;

	logic [7:0]  a_px;
	logic [7:0]  b_px;
	logic [7:0]  dr_px;
	logic [11:0] lap;
	logic [11:0] dx;
	logic [11:0] dy;
	logic [20:0] sq_sum;
	logic [8:0]  sob;
	logic [7:0]  filt;
	result_t     res;

	result_t          oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] oq_wr_q;
	logic [OQ_AW-1:0] oq_rd_q;
	logic [OQ_CW-1:0] oq_cnt_q;
	logic             oq_pop;

	// issue only while the result queue has a slot reserved for everything in flight
	assign issue  = !cq_empty && (used_q < OQ_CW'(OQ_DEPTH));
	assign cq_pop = issue;

	always_ff @(posedge clk) begin
		if (issue) begin
			rd0_q <= bank0_q[cmd.col];
			if (!cmd.drain && !cmd.sel) begin
				bank0_q[cmd.col] <= cmd.pix;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd1_q <= bank1_q[cmd.col];
			if (!cmd.drain && cmd.sel) begin
				bank1_q[cmd.col] <= cmd.pix;
			end
		end
	end

	assign a_px  = cmd_s1.sel ? rd0_q : rd1_q;
	assign b_px  = cmd_s1.sel ? rd1_q : rd0_q;
	assign dr_px = cmd_s1.sel ? rd1_q : rd0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (v_s1 && !cmd_s1.drain) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= b_px;
			win_q[1][2] <= a_px;
			win_q[2][2] <= cmd_s1.pix;
		end
	end

	always_comb begin
		lap = {2'b00, win_q[1][1], 2'b00} - {4'b0, win_q[0][1]} - {4'b0, win_q[2][1]}
			- {4'b0, win_q[1][0]} - {4'b0, win_q[1][2]};
		dx  = {4'b0, win_q[2][0]} + {3'b0, win_q[2][1], 1'b0} + {4'b0, win_q[2][2]}
			- {4'b0, win_q[0][0]} - {3'b0, win_q[0][1], 1'b0} - {4'b0, win_q[0][2]};
		dy  = {4'b0, win_q[0][2]} + {3'b0, win_q[1][2], 1'b0} + {4'b0, win_q[2][2]}
			- {4'b0, win_q[0][0]} - {3'b0, win_q[1][0], 1'b0} - {4'b0, win_q[2][0]};
	end

	assign sq_sum = {1'b0, dxx_s4} + {1'b0, dyy_s4};

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;

		pt_s2.pass <= cmd_s1.drain || cmd_s1.border;
		pt_s2.val  <= cmd_s1.drain ? dr_px : win_q[1][2];
		pt_s2.last <= cmd_s1.last;

		pt_s3   <= pt_s2;
		alap_s3 <= lap[11] ? 10'(-lap) : lap[9:0];
		dxa_s3  <= dx[11] ? 10'(-dx) : dx[9:0];
		dya_s3  <= dy[11] ? 10'(-dy) : dy[9:0];

		pt_s4   <= pt_s3;
		alap_s4 <= alap_s3;
		dxx_s4  <= dxa_s3 * dxa_s3;
		dyy_s4  <= dya_s3 * dya_s3;

		pt_s5      <= pt_s4;
		alap_s5    <= alap_s4;
		over_s5    <= (sq_sum > SOBEL_LIMIT);
		st_s5.x    <= sq_sum[15:0];
		st_s5.root <= '0;
		st_s5.rem  <= '0;

		// two root digits per stage
		pt_s6   <= pt_s5;
		alap_s6 <= alap_s5;
		over_s6 <= over_s5;
		st_s6   <= sqrt_step(sqrt_step(st_s5));

		pt_s7   <= pt_s6;
		alap_s7 <= alap_s6;
		over_s7 <= over_s6;
		st_s7   <= sqrt_step(sqrt_step(st_s6));

		pt_s8   <= pt_s7;
		alap_s8 <= alap_s7;
		over_s8 <= over_s7;
		st_s8   <= sqrt_step(sqrt_step(st_s7));

		pt_s9   <= pt_s8;
		alap_s9 <= alap_s8;
		over_s9 <= over_s8;
		st_s9   <= sqrt_step(sqrt_step(st_s8));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && cmd_s1.emit;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// 255 minus the root, rounded up when a remainder is left
	assign sob = 9'd255 - {1'b0, st_s9.root} - {8'b0, (st_s9.rem != '0)};

	always_comb begin
		case (mode)
			MODE_SOBEL:  filt = over_s9 ? 8'd0 : sob[7:0];
			MODE_LAPL:   filt = (alap_s9 > 10'd255) ? 8'd0 : 8'(10'd255 - alap_s9);
			default:     filt = 8'(8'd255 - alap_s9[9:2]);
		endcase
		res.out_pixel  = pt_s9.pass ? pt_s9.val : filt;
		res.frame_last = pt_s9.last;
	end

	assign oq_pop = pop && !empty;
	assign empty  = (oq_cnt_q == '0);
	assign result = oq_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (v_s9) begin
			oq_q[oq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
			used_q   <= '0;
		end else begin
			if (v_s9) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			if (v_s9 && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (oq_pop && !v_s9) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
			if ((issue && cmd.emit) && !oq_pop) begin
				used_q <= used_q + 1'b1;
			end else if (oq_pop && !(issue && cmd.emit)) begin
				used_q <= used_q - 1'b1;
			end
		end
	end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import isf_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int QUIET_CYCLES = 24;
	localparam int RANDOM_ITEMS = 850;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	item_t                 sample;
	logic                  empty;
	logic                  pop;
	result_t               result;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	inverted_edge_stencil_3x3_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the filter: registers, line banks, window and stream counters
	logic [1:0]   sh_mode;
	logic [10:0]  sh_width;
	logic [12:0]  sh_height;
	logic [7:0]   sh_lines [0:2*MAX_WIDTH-1];
	logic [7:0]   sh_win [0:2][0:2];
	int           sh_col;
	int           sh_row;
	int           sh_out_idx;

	// pixels still owed by the block, oldest first
	result_t      pending_pixels [$];

	int           mismatches;
	int           cycles;
	bit           push_gaps;
	bit           pop_gaps;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// geometry as the block uses it: clamped to the supported range
	function automatic int used_width();
		if (sh_width < 3) return 3;
		if (sh_width > MAX_WIDTH) return MAX_WIDTH;
		return sh_width;
	endfunction

	function automatic int used_height();
		if (sh_height < 3) return 3;
		if (sh_height > MAX_HEIGHT) return MAX_HEIGHT;
		return sh_height;
	endfunction

	function automatic int win_px(int r, int c);
		return int'(sh_win[r][c]);
	endfunction

	// 255 minus the edge strength of the window centre, floored at 0
	function automatic logic [7:0] inverted_edge();
		int lap, alap, dx, dy, v, r, b, s;
		lap  = 4 * win_px(1, 1) - win_px(0, 1) - win_px(2, 1) - win_px(1, 0) - win_px(1, 2);
		alap = lap < 0 ? -lap : lap;
		if (sh_mode == MODE_SOBEL) begin
			dx = win_px(2, 0) - win_px(0, 0) + 2 * (win_px(2, 1) - win_px(0, 1))
				+ win_px(2, 2) - win_px(0, 2);
			dy = win_px(0, 2) - win_px(0, 0) + 2 * (win_px(1, 2) - win_px(1, 0))
				+ win_px(2, 2) - win_px(2, 0);
			v = dx * dx + dy * dy;
			s = v;
			// integer root by digit recurrence, then rounded up
			r = 0;
			for (b = 1 << 30; b > 0; b = b >> 2) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
			end
			if (r * r < s) r++;
			s = r;
		end else if (sh_mode == MODE_LAPL) begin
			s = alap;
		end else begin
			// wallis, and the unused fourth code behaves the same
			s = alap >> 2;
		end
		return s > 255 ? 8'd0 : 8'(255 - s);
	endfunction

	// advance the shadow filter by one accepted item and queue any pixel it releases
	function automatic void advance_stream(bit drn, logic [7:0] p);
		int w, h, total, pin, owed, orow, ocol;
		logic [7:0] a, b, val;
		bit emit;
		result_t res;
		w     = used_width();
		h     = used_height();
		total = w * h;
		pin   = sh_row * w + sh_col;
		owed  = (pin + total - sh_out_idx) % total;
		orow  = sh_out_idx / w;
		ocol  = sh_out_idx % w;
		emit  = 1'b0;
		if (drn) begin
			// drain only flushes a finished frame with pixels still owed
			if (pin != 0 || owed == 0) return;
			val  = (orow == h - 1) ? sh_lines[ocol] : sh_lines[MAX_WIDTH + ocol];
			emit = 1'b1;
		end else begin
			a = sh_lines[sh_col];
			b = sh_lines[MAX_WIDTH + sh_col];
			sh_lines[MAX_WIDTH + sh_col] = a;
			sh_lines[sh_col] = p;
			for (int r = 0; r < 3; r++) begin
				sh_win[r][0] = sh_win[r][1];
				sh_win[r][1] = sh_win[r][2];
			end
			sh_win[0][2] = b;
			sh_win[1][2] = a;
			sh_win[2][2] = p;
			sh_col++;
			if (sh_col >= w) begin
				sh_col = 0;
				sh_row++;
				if (sh_row >= h) sh_row = 0;
			end
			if (owed + 1 == w + 2) begin
				if (orow == 0 || orow == h - 1 || ocol == 0 || ocol == w - 1)
					val = sh_win[1][1];
				else
					val = inverted_edge();
				emit = 1'b1;
			end
		end
		if (!emit) return;
		res.out_pixel  = val;
		res.frame_last = (sh_out_idx == total - 1);
		pending_pixels.push_back(res);
		sh_out_idx = (sh_out_idx + 1) % total;
	endfunction

	// result side: compare every transfer with the oldest owed pixel
	always @(posedge clk) begin
		if (arst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: pixel %0d last %0b",
						result.out_pixel, result.frame_last);
			end else begin
				if (result.out_pixel !== pending_pixels[0].out_pixel
						|| result.frame_last !== pending_pixels[0].frame_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
							pending_pixels[0].out_pixel, pending_pixels[0].frame_last,
							result.out_pixel, result.frame_last);
				end
				void'(pending_pixels.pop_front());
			end
		end
	end

	// result side: random back-pressure, pop held high until the transfer happens
	initial begin
		int n;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			n = pop_gaps ? $urandom_range(0, 5) : 0;
			repeat (n) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
		end
	end

	// send one item; push stays high afterwards so back-to-back items need no dip
	task automatic send_item(bit drn, logic [7:0] p);
		int n;
		n = push_gaps ? $urandom_range(0, 5) : 0;
		repeat (n) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push              <= 1'b1;
		sample.gray_pixel <= drn ? 8'($urandom_range(0, 255)) : p;
		sample.drain      <= drn;
		do @(posedge clk); while (full !== 1'b0);
		advance_stream(drn, p);
	endtask

	// let every owed transfer arrive, then let the pipeline settle
	task automatic wait_quiet();
		@(negedge clk);
		push <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_MODE) begin
			sh_mode = 2'(value);
		end else begin
			if (idx == REG_WIDTH) sh_width = 11'(value);
			else sh_height = 13'(value);
			// geometry change restarts the stream and forgets owed pixels
			sh_col     = 0;
			sh_row     = 0;
			sh_out_idx = 0;
		end
	endtask

	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// tail of a finished frame: width+1 drains, plus spare ones that do nothing
	task automatic flush_frame(int spare);
		repeat (used_width() + 1 + spare) send_item(1'b1, 8'd0);
	endtask

	// smallest frame, drains before the first pixel and in the middle of the frame
	task automatic test_small_frame();
		write_reg(REG_WIDTH, 3);
		write_reg(REG_HEIGHT, 3);
		write_reg(REG_MODE, MODE_SOBEL);
		send_item(1'b1, 8'd0);
		for (int i = 0; i < 9; i++) begin
			if (i == 4) send_item(1'b1, 8'd0);
			send_item(1'b0, (i % 2) ? 8'd255 : 8'd0);
		end
		flush_frame(1);
		wait_quiet();
	endtask

	// each filter code, the fourth one too, on a saturating pattern
	task automatic test_modes();
		logic [7:0] p;
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_MODE, m);
			for (int i = 0; i < 9; i++) begin
				if (m == MODE_SOBEL) p = (i % 3 == 2) ? 8'd255 : 8'd0;
				else p = (i == 4) ? 8'd255 : 8'd0;
				send_item(1'b0, p);
			end
			flush_frame(0);
			wait_quiet();
		end
	endtask

	// geometry below the supported range is clamped
	task automatic test_geometry_clamp();
		int dims [3][2] = '{'{0, 2}, '{2, 0}, '{1, 1}};
		push_gaps = 1'b0;
		pop_gaps  = 1'b0;
		for (int k = 0; k < 3; k++) begin
			write_reg(REG_MODE, $urandom_range(0, 2));
			write_reg(REG_WIDTH, dims[k][0]);
			write_reg(REG_HEIGHT, dims[k][1]);
			repeat (used_width() * used_height()) send_item(1'b0, pick_pixel());
			flush_frame(0);
			wait_quiet();
		end
		push_gaps = 1'b1;
		pop_gaps  = 1'b1;
	endtask

	// chained frames with random content, stray drains, stalls and restarts
	task automatic test_random_stream();
		int done, w, frames, cut;
		bit stale, paused;
		done   = 0;
		stale  = 1'b1;
		paused = 1'b0;
		while (done < RANDOM_ITEMS) begin
			wait_quiet();
			push_gaps = $urandom_range(0, 3) != 0;
			pop_gaps  = $urandom_range(0, 3) != 0;
			write_reg(REG_MODE, $urandom_range(0, 3));
			if (stale || $urandom_range(0, 2) != 0) begin
				write_reg(REG_WIDTH, $urandom_range(3, 10));
				write_reg(REG_HEIGHT, $urandom_range(3, 6));
				stale = 1'b0;
			end
			w      = used_width() * used_height();
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				for (int i = 0; i < w; i++) begin
					// stray drain inside an unfinished frame: ignored by the block
					if (i != 0 && $urandom_range(0, 19) == 0) send_item(1'b1, 8'd0);
					// hold the sender until the result side has caught up
					if (!paused && f == 0 && i == w / 2) begin
						@(negedge clk);
						push <= 1'b0;
						while (pending_pixels.size() != 0) @(posedge clk);
						paused = 1'b1;
					end
					send_item(1'b0, pick_pixel());
					done++;
				end
			end
			if ($urandom_range(0, 5) == 0) begin
				// abandon a partial frame; the next geometry write drops the owed pixels
				cut = $urandom_range(1, w - 1);
				repeat (cut) send_item(1'b0, pick_pixel());
				done += cut;
				stale = 1'b1;
			end else begin
				flush_frame($urandom_range(0, 2));
				done += used_width() + 1;
			end
		end
	endtask

	initial begin
		mismatches = 0;
		cycles     = 0;
		push_gaps  = 1'b1;
		pop_gaps   = 1'b1;
		push       = 1'b0;
		sample     = '0;
		cfg_we     = 1'b0;
		cfg_index  = REG_MODE;
		cfg_data   = '0;
		sh_mode    = MODE_SOBEL;
		sh_width   = 11'd640;
		sh_height  = 13'd480;
		sh_col     = 0;
		sh_row     = 0;
		sh_out_idx = 0;
		for (int i = 0; i < 2 * MAX_WIDTH; i++) sh_lines[i] = 8'd0;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) sh_win[r][c] = 8'd0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_small_frame();
		test_modes();
		test_geometry_clamp();
		test_random_stream();

		wait_quiet();
		if (pending_pixels.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/isf_pkg.sv
rtl/isf_cmdq.sv
rtl/isf_front.sv
rtl/isf_back.sv
rtl/inverted_edge_stencil_3x3_top.sv
tb/tb.sv
